### src/fla_pkg.sv
// ----------------------------------------------------------------------------
// Free list chunk allocator package
// Shared widths, codes and state encoding for the chunk allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

	localparam int POOL_CHUNKS_DEF = 1024;
	localparam int MIN_CHUNK_BYTES = 8;

	localparam int ACTION_W  = 2;
	localparam int AMOUNT_W  = 16;
	localparam int INDEX_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam int CHUNK_BYTES_W = 16;
	localparam int AUTO_GROW_W   = 11;
	localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RST = CHUNK_BYTES_W'(64);
	localparam logic [AUTO_GROW_W-1:0]   AUTO_GROW_RST   = '0;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_GROW   = 1'b1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_EXPAND = 2'd2,
		ACT_INIT   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD     = 2'd1,
		STAT_NOFREE  = 2'd2,
		STAT_EXHAUST = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_GROW,
		S_ISSUE,
		S_READ
	} state_t;

endpackage

### src/fla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/free_list_chunk_allocator_top.sv
// ----------------------------------------------------------------------------
// Free list chunk allocator
// Pool of equal-size chunks kept as a LIFO free list in a link memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and must be taken
// then. Free and rejected requests finish from the decode state, alloc from a
// non-empty list after one read of the link memory, expand and init of N
// chunks after writing N link entries, and an alloc that grows the pool by N
// chunks after writing them and then reading the new head. Growth writes one
// link entry per cycle through the single write port of the link memory.
// A new request may be taken in the cycle that shows done.
module free_list_chunk_allocator_top #(
	parameter int POOL_CHUNKS = fla_pkg::POOL_CHUNKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [fla_pkg::ACTION_W-1:0]   action,
	input  logic [fla_pkg::AMOUNT_W-1:0]   amount,
	input  logic [fla_pkg::INDEX_W-1:0]    chunk_index,
	output logic                           done,
	output logic [fla_pkg::STATUS_W-1:0]   status,
	output logic [fla_pkg::INDEX_W-1:0]    granted_index,
	output logic [fla_pkg::COUNT_W-1:0]    in_use_count,
	output logic [fla_pkg::COUNT_W-1:0]    total_capacity,
	input  logic                           cfg_we,
	input  logic [fla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fla_pkg::CFG_W-1:0]      cfg_data
);

	localparam int AW   = $clog2(POOL_CHUNKS);
	localparam int CW   = $clog2(POOL_CHUNKS + 1);
	localparam int CMPW = ((CW > fla_pkg::AMOUNT_W) ? CW : fla_pkg::AMOUNT_W) + 1;
	localparam logic [CMPW-1:0] POOL_X    = CMPW'(POOL_CHUNKS);
	localparam logic [CW-1:0]   NULL_LINK = CW'(POOL_CHUNKS);
	localparam logic [fla_pkg::CHUNK_BYTES_W-1:0] MIN_BYTES =
		fla_pkg::CHUNK_BYTES_W'(fla_pkg::MIN_CHUNK_BYTES);

	fla_pkg::state_t  state_q, state_d;
	fla_pkg::action_t action_q, action_d;
	logic [fla_pkg::AMOUNT_W-1:0]      amount_q, amount_d;
	logic [fla_pkg::INDEX_W-1:0]       idx_q, idx_d;
	logic [fla_pkg::CHUNK_BYTES_W-1:0] chunk_bytes_q;
	logic [fla_pkg::AUTO_GROW_W-1:0]   auto_grow_q;
	logic [CW-1:0] head_q, head_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] created_q, created_d;
	logic [CW-1:0] granted_q, granted_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] last_q, last_d;
	logic [AW-1:0] first_q, first_d;
	logic          pop_q, pop_d;
	logic          done_q, done_d;
	fla_pkg::status_t status_q, status_d;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [CW-1:0] ram_rdata;

	logic [CMPW-1:0] amount_x, csize_x, auto_grow_x, room_x, idx_x;
	logic [CMPW-1:0] grow_first, grow_count;
	logic            head_empty, grow_last;
	logic            dec_finish, dec_grow, dec_read, dec_pop, dec_free_ok;
	fla_pkg::status_t dec_status;

	fla_ram #(
		.WIDTH(CW),
		.DEPTH(POOL_CHUNKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign amount_x    = CMPW'(amount_q);
	assign csize_x     = CMPW'((chunk_bytes_q < MIN_BYTES) ? MIN_BYTES : chunk_bytes_q);
	assign auto_grow_x = CMPW'(auto_grow_q);
	assign room_x      = POOL_X - CMPW'(created_q);
	assign idx_x       = CMPW'(idx_q);
	assign head_empty  = (head_q >= NULL_LINK);
	assign grow_last   = (ptr_q == last_q);

	// Decision taken in the decode cycle, from the captured request, the pool state and the configuration.
	always_comb begin
		dec_finish  = 1'b0;
		dec_grow    = 1'b0;
		dec_read    = 1'b0;
		dec_pop     = 1'b0;
		dec_free_ok = 1'b0;
		dec_status  = fla_pkg::STAT_OK;
		grow_first  = CMPW'(created_q);
		grow_count  = amount_x;
		case (action_q)
			fla_pkg::ACT_ALLOC: begin
				if (amount_x > csize_x) begin
					dec_finish = 1'b1;
					dec_status = fla_pkg::STAT_BAD;
				end else if (head_empty) begin
					grow_count = auto_grow_x;
					if (auto_grow_x == '0) begin
						dec_finish = 1'b1;
						dec_status = fla_pkg::STAT_NOFREE;
					end else if (auto_grow_x > room_x) begin
						dec_finish = 1'b1;
						dec_status = fla_pkg::STAT_EXHAUST;
					end else begin
						dec_grow = 1'b1;
						dec_pop  = 1'b1;
					end
				end else begin
					dec_read = 1'b1;
				end
			end
			fla_pkg::ACT_FREE: begin
				dec_finish = 1'b1;
				if (idx_x >= POOL_X) begin
					dec_status = fla_pkg::STAT_BAD;
				end else begin
					dec_free_ok = 1'b1;
				end
			end
			fla_pkg::ACT_EXPAND: begin
				if (amount_x == '0) begin
					dec_finish = 1'b1;
					dec_status = fla_pkg::STAT_BAD;
				end else if (amount_x > room_x) begin
					dec_finish = 1'b1;
					dec_status = fla_pkg::STAT_EXHAUST;
				end else begin
					dec_grow = 1'b1;
				end
			end
			default: begin
				grow_first = '0;
				if (amount_x == '0) begin
					dec_finish = 1'b1;
					dec_status = fla_pkg::STAT_BAD;
				end else if (amount_x > POOL_X) begin
					dec_finish = 1'b1;
					dec_status = fla_pkg::STAT_EXHAUST;
				end else begin
					dec_grow = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fla_pkg::S_IDLE: begin
				if (start) begin
					state_d = fla_pkg::S_DECODE;
				end
			end
			fla_pkg::S_DECODE: begin
				if (dec_grow) begin
					state_d = fla_pkg::S_GROW;
				end else if (dec_read) begin
					state_d = fla_pkg::S_READ;
				end else begin
					state_d = fla_pkg::S_IDLE;
				end
			end
			fla_pkg::S_GROW: begin
				if (grow_last) begin
					state_d = pop_q ? fla_pkg::S_ISSUE : fla_pkg::S_IDLE;
				end
			end
			fla_pkg::S_ISSUE: begin
				state_d = fla_pkg::S_READ;
			end
			fla_pkg::S_READ: begin
				state_d = fla_pkg::S_IDLE;
			end
			default: begin
				state_d = fla_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		action_d  = action_q;
		amount_d  = amount_q;
		idx_d     = idx_q;
		head_d    = head_q;
		used_d    = used_q;
		created_d = created_q;
		granted_d = granted_q;
		ptr_d     = ptr_q;
		last_d    = last_q;
		first_d   = first_q;
		pop_d     = pop_q;
		status_d  = status_q;
		done_d    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = head_q;
		ram_re    = 1'b0;
		ram_raddr = AW'(head_q);
		case (state_q)
			fla_pkg::S_IDLE: begin
				if (start) begin
					action_d = fla_pkg::action_t'(action);
					amount_d = amount;
					idx_d    = chunk_index;
				end
			end
			fla_pkg::S_DECODE: begin
				if (dec_finish) begin
					done_d    = 1'b1;
					status_d  = dec_status;
					granted_d = '0;
				end
				if (dec_free_ok) begin
					// Push the returned chunk in front of the current head.
					ram_we    = 1'b1;
					ram_waddr = AW'(idx_x);
					ram_wdata = head_q;
					head_d    = CW'(idx_x);
					if (used_q != '0) begin
						used_d = used_q - 1'b1;
					end
				end
				if (dec_grow) begin
					ptr_d   = AW'(grow_first);
					first_d = AW'(grow_first);
					last_d  = AW'(grow_first + grow_count - 1'b1);
					pop_d   = dec_pop;
					if (action_q == fla_pkg::ACT_INIT) begin
						head_d    = NULL_LINK;
						used_d    = '0;
						created_d = '0;
					end
				end
				if (dec_read) begin
					ram_re = 1'b1;
				end
			end
			fla_pkg::S_GROW: begin
				// Each fresh chunk links to the next one; the last links to the old head.
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = grow_last ? head_q : CW'(CMPW'(ptr_q) + 1'b1);
				ptr_d     = AW'(CMPW'(ptr_q) + 1'b1);
				if (grow_last) begin
					head_d    = CW'(first_q);
					created_d = CW'(CMPW'(last_q) + 1'b1);
					if (!pop_q) begin
						done_d    = 1'b1;
						status_d  = fla_pkg::STAT_OK;
						granted_d = '0;
					end
				end
			end
			fla_pkg::S_ISSUE: begin
				ram_re = 1'b1;
			end
			fla_pkg::S_READ: begin
				granted_d = head_q;
				head_d    = ram_rdata;
				if (used_q < NULL_LINK) begin
					used_d = CW'(CMPW'(used_q) + 1'b1);
				end
				done_d   = 1'b1;
				status_d = fla_pkg::STAT_OK;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fla_pkg::S_IDLE;
			head_q        <= NULL_LINK;
			used_q        <= '0;
			created_q     <= '0;
			done_q        <= 1'b0;
			pop_q         <= 1'b0;
			chunk_bytes_q <= fla_pkg::CHUNK_BYTES_RST;
			auto_grow_q   <= fla_pkg::AUTO_GROW_RST;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			used_q    <= used_d;
			created_q <= created_d;
			done_q    <= done_d;
			pop_q     <= pop_d;
			if (cfg_we) begin
				if (cfg_index == fla_pkg::CFG_CHUNK_BYTES) begin
					chunk_bytes_q <= cfg_data;
				end else if (cfg_index == fla_pkg::CFG_AUTO_GROW) begin
					auto_grow_q <= fla_pkg::AUTO_GROW_W'(cfg_data);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		action_q  <= action_d;
		amount_q  <= amount_d;
		idx_q     <= idx_d;
		granted_q <= granted_d;
		ptr_q     <= ptr_d;
		last_q    <= last_d;
		first_q   <= first_d;
		status_q  <= status_d;
	end

	assign busy           = (state_q != fla_pkg::S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign granted_index  = fla_pkg::INDEX_W'(granted_q);
	assign in_use_count   = fla_pkg::COUNT_W'(used_q);
	assign total_capacity = fla_pkg::COUNT_W'(created_q);

endmodule

### src/fla_checker.sv
// ----------------------------------------------------------------------------
// Free list chunk allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fla_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [fla_pkg::STATUS_W-1:0]  status,
	input logic [fla_pkg::INDEX_W-1:0]   granted_index,
	input logic [fla_pkg::COUNT_W-1:0]   in_use_count,
	input logic [fla_pkg::COUNT_W-1:0]   total_capacity
);

	// A result is only shown once the block has finished its request.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// An accepted request always occupies the block in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted request did not make the block busy");

	// Only a successful allocation hands out a chunk index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != fla_pkg::STAT_OK) |-> (granted_index == '0))
		else $error("chunk index given with a failing status");

	// The counts move only while a request is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> ($stable(in_use_count) && $stable(total_capacity)))
		else $error("counts changed while idle");

endmodule

bind free_list_chunk_allocator_top fla_checker u_fla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.granted_index (granted_index),
	.in_use_count  (in_use_count),
	.total_capacity(total_capacity)
);
